[hw/rtl/generational_handle_slot_allocator_assert.svh]
// assertion macros for the generational handle slot allocator
// uses clk and rst of the including module; empty under SYNTHESIS
`ifndef GENERATIONAL_HANDLE_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define GHSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GHSA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHSA_ASSERT(label, prop, msg)
`define GHSA_ASSERT_RST(label, prop, msg)
`endif
`endif

[hw/rtl/ghsa_pkg.sv]
// shared constants for the generational handle slot allocator
// no dependencies
package ghsa_pkg;

  localparam int SLOTS    = 256;
  localparam int CAPACITY = (SLOTS < 256) ? SLOTS : 256;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int GEN_W    = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_STALE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd5;

endpackage

[hw/rtl/ghsa_ram.sv]
// simple dual port ram, one write and one registered read per cycle
// no dependencies
module ghsa_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/generational_handle_slot_allocator.sv]
// generational handle slot allocator top level
// depends on ghsa_pkg, ghsa_ram and generational_handle_slot_allocator_assert.svh
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall    cmd, slot_index, handle_gen
//  out      source     out_valid / out_stall  status, out_index, out_gen
//  cfg      sink       cfg_wen                cfg_wdata (first generation)
//
// one item at a time: clear, errors and fresh allocs finish in the exec step; free,
// lookup and reverse lookup add one generation ram read, and an alloc off the
// free stack adds a stack ram read, then a generation ram read
// the result sits in an output register, so the next item is taken while it waits
// a stalled output holds the item in its last step until the register frees up
// synchronous reset empties the pool and sets the first generation to 1; no ram clear
`include "generational_handle_slot_allocator_assert.svh"

module generational_handle_slot_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ghsa_pkg::CMD_W-1:0]    cmd,
  input  logic [ghsa_pkg::IDX_W-1:0]    slot_index,
  input  logic [ghsa_pkg::GEN_W-1:0]    handle_gen,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ghsa_pkg::STAT_W-1:0]   status,
  output logic [ghsa_pkg::IDX_W-1:0]    out_index,
  output logic [ghsa_pkg::GEN_W-1:0]    out_gen,
  input  logic                          cfg_wen,
  input  logic [ghsa_pkg::GEN_W-1:0]    cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_RGEN = 2'd3;

  logic [1:0]                     state, state_next;
  logic [ghsa_pkg::CMD_W-1:0]     c_cmd;
  logic [ghsa_pkg::IDX_W-1:0]     c_idx, c_idx_next;
  logic [ghsa_pkg::GEN_W-1:0]     c_gen;
  logic [ghsa_pkg::GEN_W-1:0]     first_gen;
  logic [ghsa_pkg::CNT_W-1:0]     stack_count, stack_count_next;
  logic [ghsa_pkg::CNT_W-1:0]     watermark, watermark_next;

  logic                           out_free, fin;
  logic [ghsa_pkg::STAT_W-1:0]    res_status;
  logic [ghsa_pkg::IDX_W-1:0]     res_index;
  logic [ghsa_pkg::GEN_W-1:0]     res_gen;
  logic                           in_range;
  logic [ghsa_pkg::GEN_W-1:0]     bumped;

  logic                           gen_we, gen_re;
  logic [ghsa_pkg::IDX_W-1:0]     gen_waddr, gen_raddr;
  logic [ghsa_pkg::GEN_W-1:0]     gen_wdata, gen_rdata;
  logic                           stk_we, stk_re;
  logic [ghsa_pkg::IDX_W-1:0]     stk_waddr, stk_raddr;
  logic [ghsa_pkg::IDX_W-1:0]     stk_wdata, stk_rdata;

  ghsa_ram #(.ADDR_W(ghsa_pkg::IDX_W), .DATA_W(ghsa_pkg::GEN_W)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .re    (gen_re),
    .raddr (gen_raddr),
    .rdata (gen_rdata)
  );

  ghsa_ram #(.ADDR_W(ghsa_pkg::IDX_W), .DATA_W(ghsa_pkg::IDX_W)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign in_range = ({1'b0, c_idx} < watermark);

  // free bumps the generation and skips zero
  always_comb begin
    bumped = gen_rdata + ghsa_pkg::GEN_W'(1);
    if (bumped == '0) begin
      bumped = ghsa_pkg::GEN_W'(1);
    end
  end

  always_comb begin
    state_next       = state;
    c_idx_next       = c_idx;
    stack_count_next = stack_count;
    watermark_next   = watermark;
    fin              = 1'b0;
    res_status       = ghsa_pkg::ST_OK;
    res_index        = '0;
    res_gen          = '0;
    gen_we           = 1'b0;
    gen_waddr        = c_idx;
    gen_wdata        = bumped;
    gen_re           = 1'b0;
    gen_raddr        = c_idx;
    stk_we           = 1'b0;
    stk_waddr        = stack_count[ghsa_pkg::IDX_W-1:0];
    stk_wdata        = c_idx;
    stk_re           = 1'b0;
    stk_raddr        = stack_count[ghsa_pkg::IDX_W-1:0] - ghsa_pkg::IDX_W'(1);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
          c_idx_next = slot_index;
        end
      end
      S_EXEC: begin
        unique case (c_cmd)
          ghsa_pkg::CMD_ALLOC: begin
            if (stack_count != '0) begin
              stk_re           = 1'b1;
              stack_count_next = stack_count - ghsa_pkg::CNT_W'(1);
              state_next       = S_POP;
            end else if (out_free) begin
              fin = 1'b1;
              if (watermark < ghsa_pkg::CAP_CNT) begin
                gen_we         = 1'b1;
                gen_waddr      = watermark[ghsa_pkg::IDX_W-1:0];
                gen_wdata      = first_gen;
                watermark_next = watermark + ghsa_pkg::CNT_W'(1);
                res_index      = watermark[ghsa_pkg::IDX_W-1:0];
                res_gen        = first_gen;
              end else begin
                res_status = ghsa_pkg::ST_FULL;
              end
            end
          end
          ghsa_pkg::CMD_FREE: begin
            if (in_range && stack_count < ghsa_pkg::CAP_CNT) begin
              gen_re     = 1'b1;
              state_next = S_RGEN;
            end else if (out_free) begin
              fin        = 1'b1;
              res_status = in_range ? ghsa_pkg::ST_OVERFLOW : ghsa_pkg::ST_RANGE;
            end
          end
          ghsa_pkg::CMD_LOOKUP: begin
            if (c_idx == '0 && c_gen == '0) begin
              if (out_free) begin
                fin        = 1'b1;
                res_status = ghsa_pkg::ST_NULL;
              end
            end else if (in_range) begin
              gen_re     = 1'b1;
              state_next = S_RGEN;
            end else if (out_free) begin
              fin        = 1'b1;
              res_status = ghsa_pkg::ST_RANGE;
            end
          end
          ghsa_pkg::CMD_REVERSE: begin
            if (in_range) begin
              gen_re     = 1'b1;
              state_next = S_RGEN;
            end else if (out_free) begin
              fin        = 1'b1;
              res_status = ghsa_pkg::ST_RANGE;
            end
          end
          ghsa_pkg::CMD_CLEAR: begin
            if (out_free) begin
              fin              = 1'b1;
              stack_count_next = '0;
              watermark_next   = '0;
            end
          end
          default: begin
            fin = out_free;
          end
        endcase
      end
      S_POP: begin
        // popped slot is known now, fetch its generation
        gen_re     = 1'b1;
        gen_raddr  = stk_rdata;
        c_idx_next = stk_rdata;
        state_next = S_RGEN;
      end
      S_RGEN: begin
        if (out_free) begin
          fin       = 1'b1;
          res_index = c_idx;
          res_gen   = gen_rdata;
          if (c_cmd == ghsa_pkg::CMD_FREE) begin
            gen_we           = 1'b1;
            stk_we           = 1'b1;
            stack_count_next = stack_count + ghsa_pkg::CNT_W'(1);
            res_gen          = bumped;
          end else if (c_cmd == ghsa_pkg::CMD_LOOKUP && gen_rdata != c_gen) begin
            res_status = ghsa_pkg::ST_STALE;
            res_index  = '0;
            res_gen    = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_count <= '0;
      watermark   <= '0;
      first_gen   <= ghsa_pkg::GEN_W'(1);
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      stack_count <= stack_count_next;
      watermark   <= watermark_next;
      if (cfg_wen) begin
        first_gen <= cfg_wdata;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_idx <= c_idx_next;
    if (state == S_IDLE) begin
      c_cmd <= cmd;
      c_gen <= handle_gen;
    end
    if (fin) begin
      status    <= res_status;
      out_index <= res_index;
      out_gen   <= res_gen;
    end
  end

  `GHSA_ASSERT_RST(a_reset_idle, rst |=> (state == S_IDLE) && !out_valid && (stack_count == '0), "reset did not empty the pool")
  `GHSA_ASSERT(a_count_cap, stack_count <= ghsa_pkg::CAP_CNT, "free stack count beyond capacity")
  `GHSA_ASSERT(a_accept_exec, in_valid && !in_stall |=> state == S_EXEC, "accepted beat not executed")
  `GHSA_ASSERT(a_fin_no_clobber, fin |-> !out_valid || !out_stall, "result overwrote a stalled beat")
  `GHSA_ASSERT(a_pop_then_read, state == S_POP |=> state == S_RGEN, "stack pop not followed by read")

endmodule

[tb/ghsa_checker.sv]
// channel checker for the generational handle slot allocator: predicts every result
// from accepted input beats and config writes, then compares output beats in order
// depends on ghsa_pkg
module ghsa_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ghsa_pkg::CMD_W-1:0]  cmd,
  input  logic [ghsa_pkg::IDX_W-1:0]  slot_index,
  input  logic [ghsa_pkg::GEN_W-1:0]  handle_gen,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ghsa_pkg::STAT_W-1:0] status,
  input  logic [ghsa_pkg::IDX_W-1:0]  out_index,
  input  logic [ghsa_pkg::GEN_W-1:0]  out_gen,
  input  logic                        cfg_wen,
  input  logic [ghsa_pkg::GEN_W-1:0]  cfg_wdata,
  output int                          errors,
  output int                          outstanding,
  output logic [ghsa_pkg::GEN_W-1:0]  slot_gen [ghsa_pkg::CAPACITY],
  output logic [ghsa_pkg::CNT_W-1:0]  used_slots
);
  import ghsa_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic [IDX_W-1:0]  slot;
    logic [GEN_W-1:0]  gen;
  } reply_t;

  reply_t            reply_q [$];
  logic [GEN_W-1:0]  first_gen;
  logic [IDX_W-1:0]  free_slots [CAPACITY];
  logic [CNT_W-1:0]  stack_depth;

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // applies one request to the pool and returns the answer it should give
  function automatic reply_t pool_reply(input logic [CMD_W-1:0] op,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [GEN_W-1:0] hg);
    reply_t r;
    logic [GEN_W-1:0] g;
    r = '{stat: ST_OK, slot: '0, gen: '0};
    case (op)
      CMD_ALLOC: begin
        if (stack_depth != 0) begin
          stack_depth = stack_depth - CNT_W'(1);
          r.slot = free_slots[stack_depth];
          r.gen = slot_gen[r.slot];
        end else if (used_slots < CAP_CNT) begin
          r.slot = used_slots[IDX_W-1:0];
          slot_gen[r.slot] = first_gen;
          used_slots = used_slots + CNT_W'(1);
          r.gen = first_gen;
        end else begin
          r.stat = ST_FULL;
        end
      end
      CMD_FREE: begin
        if ({1'b0, idx} >= used_slots) begin
          r.stat = ST_RANGE;
        end else if (stack_depth >= CAP_CNT) begin
          r.stat = ST_OVERFLOW;
        end else begin
          // generation zero is never handed out
          g = slot_gen[idx] + GEN_W'(1);
          if (g == 0) g = 1;
          slot_gen[idx] = g;
          free_slots[stack_depth] = idx;
          stack_depth = stack_depth + CNT_W'(1);
          r.slot = idx;
          r.gen = g;
        end
      end
      CMD_LOOKUP: begin
        if (idx == 0 && hg == 0) r.stat = ST_NULL;
        else if ({1'b0, idx} >= used_slots) r.stat = ST_RANGE;
        else if (slot_gen[idx] != hg) r.stat = ST_STALE;
        else begin
          r.slot = idx;
          r.gen = hg;
        end
      end
      CMD_REVERSE: begin
        if ({1'b0, idx} >= used_slots) r.stat = ST_RANGE;
        else begin
          r.slot = idx;
          r.gen = slot_gen[idx];
        end
      end
      CMD_CLEAR: begin
        stack_depth = '0;
        used_slots = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      reply_q.delete();
      errors = 0;
      first_gen = 1;
      stack_depth = '0;
      used_slots = '0;
      // zeroed only so the stimulus side never reads unknowns
      for (int i = 0; i < CAPACITY; i++) slot_gen[i] = '0;
    end else begin
      if (cfg_wen) first_gen = cfg_wdata;
      if (in_valid && !in_stall) reply_q.push_back(pool_reply(cmd, slot_index, handle_gen));
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report("beat with nothing pending, status", 32'(status), '0);
        end else begin
          want = reply_q.pop_front();
          if (status !== want.stat) report("status", 32'(status), 32'(want.stat));
          if (out_index !== want.slot) report("out_index", 32'(out_index), 32'(want.slot));
          if (out_gen !== want.gen) report("out_gen", out_gen, want.gen);
        end
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

[tb/testbench.sv]
// top of the allocator testbench: clock, reset, stimulus, output stall and verdict
// depends on ghsa_pkg, generational_handle_slot_allocator and ghsa_checker
module testbench;
  import ghsa_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd = CMD_ALLOC;
  logic [IDX_W-1:0]   slot_index = '0;
  logic [GEN_W-1:0]   handle_gen = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [IDX_W-1:0]   out_index;
  logic [GEN_W-1:0]   out_gen;
  logic               cfg_wen = 1'b0;
  logic [GEN_W-1:0]   cfg_wdata = '0;

  int                 errors;
  int                 outstanding;
  logic [GEN_W-1:0]   slot_gen [CAPACITY];
  logic [CNT_W-1:0]   used_slots;

  logic               steady = 1'b0;
  int unsigned        hold_asks = 0;
  int unsigned        holds_done = 0;
  int unsigned        sent = 0;
  int unsigned        cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  generational_handle_slot_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot_index(slot_index), .handle_gen(handle_gen),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_index(out_index), .out_gen(out_gen),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  ghsa_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot_index(slot_index), .handle_gen(handle_gen),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_index(out_index), .out_gen(out_gen),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .errors(errors), .outstanding(outstanding),
    .slot_gen(slot_gen), .used_slots(used_slots)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall before each beat, one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (hold_asks != holds_done) begin
        gap = HOLD_CYCLES;
        holds_done++;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [GEN_W-1:0] hg);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    slot_index <= idx;
    handle_gen <= hg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write only with the pool idle
  task automatic write_first_gen(input logic [GEN_W-1:0] value);
    drain();
    repeat (6) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // mostly well-formed traffic on live slots, some noise
  task automatic churn_item;
    int unsigned roll;
    int unsigned mark;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] hg;
    mark = int'(used_slots);
    roll = $urandom_range(0, 99);
    idx = (mark != 0) ? IDX_W'($urandom_range(0, mark - 1)) : IDX_W'($urandom);
    hg = (mark != 0) ? slot_gen[idx] : $urandom;
    if (roll < 35) send_item(CMD_ALLOC, IDX_W'($urandom), $urandom);
    else if (roll < 60) send_item(CMD_FREE, idx, $urandom);
    else if (roll < 78) send_item(CMD_LOOKUP, idx, hg);
    else if (roll < 84) send_item(CMD_LOOKUP, idx, hg ^ (32'd1 << $urandom_range(0, 31)));
    else if (roll < 92) send_item(CMD_REVERSE, idx, $urandom);
    else if (roll < 96) send_item(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom), $urandom);
    else if (roll < 98) send_item(CMD_W'($urandom_range(5, 7)), IDX_W'($urandom), $urandom);
    else send_item(CMD_LOOKUP, '0, '0);
  endtask

  initial begin : stimulus
    logic [GEN_W-1:0] value;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty pool: every check path before any slot exists, then allocs, frees, bad commands and clear
    send_item(CMD_LOOKUP, 8'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd5, 32'd7);
    send_item(CMD_REVERSE, 8'd0, 32'd0);
    send_item(CMD_FREE, 8'd0, 32'd0);
    send_item(CMD_ALLOC, 8'd0, 32'd0);
    send_item(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 8'd1, 32'd1);
    send_item(CMD_LOOKUP, 8'd1, 32'd2);
    send_item(CMD_LOOKUP, 8'd0, 32'd0);
    send_item(CMD_FREE, 8'd1, 32'd0);
    send_item(CMD_LOOKUP, 8'd1, 32'd1);
    send_item(CMD_LOOKUP, 8'd1, 32'd2);
    // double free goes unnoticed, the slot is stacked twice
    send_item(CMD_FREE, 8'd1, 32'd0);
    send_item(CMD_ALLOC, 8'd0, 32'd0);
    send_item(CMD_ALLOC, 8'd0, 32'd0);
    send_item(CMD_REVERSE, 8'd0, 32'd0);
    send_item(CMD_W'(5), 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_W'(6), 8'h55, 32'hAAAA_AAAA);
    send_item(CMD_W'(7), 8'hAA, 32'h5555_5555);
    send_item(CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 8'd0, 32'd0);
    send_item(CMD_REVERSE, 8'd0, 32'd0);

    // top generation wraps to one on free
    write_first_gen(32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 8'd0, 32'd0);
    send_item(CMD_FREE, 8'd0, 32'd0);
    send_item(CMD_LOOKUP, 8'd0, 32'd1);

    // first random episode runs back to back against a long output hold-off
    write_first_gen(32'd1);
    sent = 0;
    steady = 1'b1;
    hold_asks++;
    repeat (40) churn_item();

    while (sent < RANDOM_ITEMS / 8) begin
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 40)) churn_item();
      case ($urandom_range(0, 9))
        0: send_item(CMD_CLEAR, IDX_W'($urandom), $urandom);
        1: begin
          value = $urandom;
          if (value == 0) value = 1;
          write_first_gen(value);
          send_item(CMD_CLEAR, IDX_W'($urandom), $urandom);
        end
        default: ;
      endcase
    end

    // fill every slot until full, then stack frees until the stack overflows
    write_first_gen(32'hFFFF_FFFE);
    steady = 1'b0;
    send_item(CMD_CLEAR, 8'd0, 32'd0);
    repeat (CAPACITY + 1) send_item(CMD_ALLOC, IDX_W'($urandom), $urandom);
    repeat (CAPACITY + 1) send_item(CMD_FREE, IDX_W'($urandom), $urandom);
    repeat (30) churn_item();

    sent = 0;
    while (sent < RANDOM_ITEMS / 8) begin
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 40)) churn_item();
      if ($urandom_range(0, 5) == 0) begin
        value = $urandom;
        if (value == 0) value = 1;
        write_first_gen(value);
        send_item(CMD_CLEAR, IDX_W'($urandom), $urandom);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
